@@ design/isp_pkg.sv @@
package isp_pkg;

  localparam int MAX_INST_DEF = 16;
  localparam int SLOT_W       = 4;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_SELECT = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NONE       = 2'd1;
  localparam logic [1:0] ST_NOT_LETTER = 2'd2;
  localparam logic [1:0] ST_BAD        = 2'd3;

  localparam logic [1:0] MODE_RR   = 2'd0;
  localparam logic [1:0] MODE_MOST = 2'd1;
  localparam logic [1:0] MODE_KEY  = 2'd2;

  localparam logic [7:0] CHR_LOW_A = 8'd97;
  localparam logic [7:0] CHR_LOW_Z = 8'd122;
  localparam logic [7:0] CHR_UP_A  = 8'd65;
  localparam logic [7:0] CHR_UP_Z  = 8'd90;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  slot;
    logic [15:0] free_space;
    logic [7:0]  key_char;
    logic        restore_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] chosen_slot;
    logic [4:0] instance_count;
  } out_result_t;

  typedef enum logic [1:0] {
    PLAN_DONE  = 2'd0,
    PLAN_SHIFT = 2'd1,
    PLAN_SCAN  = 2'd2,
    PLAN_DIV   = 2'd3
  } plan_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic shift;
    logic scan;
    logic divide;
  } dp_cmd_t;

  typedef struct packed {
    logic  fin;
    plan_t plan;
  } dp_stat_t;

  // letters per group: ceil(26 / count)
  function automatic logic [4:0] group_width(input logic [7:0] n);
    logic [4:0] w;
    if (n >= 8'd26) begin
      w = 5'd1;
    end else if (n >= 8'd13) begin
      w = 5'd2;
    end else if (n >= 8'd9) begin
      w = 5'd3;
    end else if (n >= 8'd7) begin
      w = 5'd4;
    end else if (n == 8'd6) begin
      w = 5'd5;
    end else if (n == 8'd5) begin
      w = 5'd6;
    end else if (n == 8'd4) begin
      w = 5'd7;
    end else if (n == 8'd3) begin
      w = 5'd9;
    end else if (n == 8'd2) begin
      w = 5'd13;
    end else begin
      w = 5'd26;
    end
    return w;
  endfunction

endpackage

@@ design/isp_ctrl.sv @@
module isp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  isp_pkg::dp_stat_t  stat,
  output isp_pkg::dp_cmd_t   cmd,
  output logic               busy
);
  import isp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DIV    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.fin) begin
          state_nxt = S_IDLE;
        end else begin
          case (stat.plan)
            PLAN_SHIFT: state_nxt = S_SHIFT;
            PLAN_SCAN:  state_nxt = S_SCAN;
            PLAN_DIV:   state_nxt = S_DIV;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_SHIFT, S_SCAN, S_DIV: begin
        if (stat.fin) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && start;
  assign cmd.decide = (state_r == S_DECIDE);
  assign cmd.shift  = (state_r == S_SHIFT);
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.divide = (state_r == S_DIV);

endmodule

@@ design/isp_dp.sv @@
module isp_dp #(
  parameter int MAX_INSTANCES = isp_pkg::MAX_INST_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  isp_pkg::in_item_t    in_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_data,
  input  isp_pkg::dp_cmd_t     cmd,
  output isp_pkg::dp_stat_t    stat,
  output logic                 out_valid,
  output isp_pkg::out_result_t out_result
);
  import isp_pkg::*;

  localparam int CW = $clog2(MAX_INSTANCES + 1);
  localparam int AW = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int QW = (XW > 5) ? XW : 5;

  logic [15:0]   mem [MAX_INSTANCES];

  in_item_t      item_r;
  logic [1:0]    mode_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rot_r, rot_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [15:0]   rd_data_r;
  logic [15:0]   best_val_r, best_val_nxt;
  logic [CW-1:0] best_idx_r, best_idx_nxt;
  logic [4:0]    rem_r, rem_nxt;
  logic [4:0]    quot_r, quot_nxt;
  logic [4:0]    per_r, per_nxt;
  out_result_t   res_r;
  logic          out_valid_r;

  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;
  logic [AW-1:0] ra;
  logic          fin;
  plan_t         plan;
  logic [1:0]    st;
  logic [QW-1:0] chosen_w;

  logic [XW-1:0] slot_x, count_x;
  logic          slot_ok;
  logic [CW-1:0] slot_c, slot_inc, ptr_inc, ptr_dec;
  logic          is_lower, is_upper;
  logic [4:0]    letter_ix;
  logic          take;

  assign slot_x   = XW'(item_r.slot);
  assign count_x  = XW'(count_r);
  assign slot_ok  = slot_x < count_x;
  assign slot_c   = slot_x[CW-1:0];
  assign slot_inc = slot_c + CW'(1);
  assign ptr_inc  = ptr_r + CW'(1);
  assign ptr_dec  = ptr_r - CW'(1);
  assign is_lower = (item_r.key_char >= CHR_LOW_A) && (item_r.key_char <= CHR_LOW_Z);
  assign is_upper = (item_r.key_char >= CHR_UP_A) && (item_r.key_char <= CHR_UP_Z);
  assign letter_ix = is_lower ? 5'(item_r.key_char - CHR_LOW_A)
                              : 5'(item_r.key_char - CHR_UP_A);
  assign take     = (ptr_r == '0) || (rd_data_r > best_val_r);

  always_comb begin
    count_nxt    = count_r;
    rot_nxt      = rot_r;
    ptr_nxt      = ptr_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    rem_nxt      = rem_r;
    quot_nxt     = quot_r;
    per_nxt      = per_r;
    we           = 1'b0;
    wa           = '0;
    wd           = item_r.free_space;
    ra           = ptr_r[AW-1:0];
    fin          = 1'b0;
    plan         = PLAN_DONE;
    st           = ST_OK;
    chosen_w     = '0;

    if (cmd.decide) begin
      case (item_r.operation)
        OP_ADD: begin
          fin = 1'b1;
          if (count_r >= CW'(MAX_INSTANCES)) begin
            st = ST_BAD;
          end else begin
            we        = 1'b1;
            wa        = count_r[AW-1:0];
            chosen_w  = QW'(count_r);
            count_nxt = count_r + CW'(1);
          end
        end
        OP_REMOVE: begin
          if (!slot_ok) begin
            fin = 1'b1;
            st  = ST_BAD;
          end else if (slot_inc == count_r) begin
            fin       = 1'b1;
            chosen_w  = QW'(slot_c);
            count_nxt = count_r - CW'(1);
          end else begin
            plan    = PLAN_SHIFT;
            ptr_nxt = slot_inc;
            ra      = slot_inc[AW-1:0];
          end
        end
        OP_UPDATE: begin
          fin = 1'b1;
          if (!slot_ok) begin
            st = ST_BAD;
          end else begin
            we       = 1'b1;
            wa       = slot_c[AW-1:0];
            chosen_w = QW'(slot_c);
          end
        end
        OP_SELECT: begin
          case (mode_r)
            MODE_RR: begin
              fin = 1'b1;
              if (count_r == '0) begin
                st      = ST_NONE;
                rot_nxt = item_r.restore_index ? rot_r : '0;
              end else if (rot_r >= count_r) begin
                rot_nxt = item_r.restore_index ? rot_r : CW'(1);
              end else begin
                chosen_w = QW'(rot_r);
                rot_nxt  = item_r.restore_index ? rot_r : rot_r + CW'(1);
              end
            end
            MODE_MOST: begin
              if (count_r == '0) begin
                fin = 1'b1;
                st  = ST_NONE;
              end else begin
                plan    = PLAN_SCAN;
                ptr_nxt = '0;
                ra      = '0;
              end
            end
            MODE_KEY: begin
              if (!(is_lower || is_upper)) begin
                fin = 1'b1;
                st  = ST_NOT_LETTER;
              end else if (count_r == '0) begin
                fin = 1'b1;
                st  = ST_NONE;
              end else begin
                plan     = PLAN_DIV;
                rem_nxt  = letter_ix;
                quot_nxt = '0;
                per_nxt  = group_width(8'(count_r));
              end
            end
            default: begin
              fin = 1'b1;
              st  = ST_NONE;
            end
          endcase
        end
        default: begin
          fin = 1'b1;
          st  = ST_BAD;
        end
      endcase
    end

    // move entries up by one, one per cycle
    if (cmd.shift) begin
      we      = 1'b1;
      wa      = ptr_dec[AW-1:0];
      wd      = rd_data_r;
      ra      = ptr_inc[AW-1:0];
      ptr_nxt = ptr_inc;
      if (ptr_inc == count_r) begin
        fin       = 1'b1;
        chosen_w  = QW'(slot_c);
        count_nxt = count_r - CW'(1);
      end
    end

    // first entry with the most free space
    if (cmd.scan) begin
      if (take) begin
        best_val_nxt = rd_data_r;
        best_idx_nxt = ptr_r;
      end
      ra      = ptr_inc[AW-1:0];
      ptr_nxt = ptr_inc;
      if (ptr_inc == count_r) begin
        fin      = 1'b1;
        chosen_w = QW'(best_idx_nxt);
      end
    end

    // letter group by repeated subtraction
    if (cmd.divide) begin
      if (rem_r >= per_r) begin
        rem_nxt  = rem_r - per_r;
        quot_nxt = quot_r + 5'd1;
      end else begin
        fin      = 1'b1;
        chosen_w = QW'(quot_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    ptr_r      <= ptr_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    rem_r      <= rem_nxt;
    quot_r     <= quot_nxt;
    per_r      <= per_nxt;
    if (fin) begin
      res_r.status         <= st;
      res_r.chosen_slot    <= chosen_w[3:0];
      res_r.instance_count <= 5'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RR;
      count_r     <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      count_r     <= count_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= fin;
    end
  end

  assign stat.fin   = fin;
  assign stat.plan  = plan;
  assign out_valid  = out_valid_r;
  assign out_result = res_r;

endmodule

@@ design/instance_selector_policy.sv @@
// add, update, round robin and rejects finish in the decide state; out_valid is registered from it
// remove: the shift state moves one table entry per cycle, from the entry after the slot to the last
// most free space: the scan state does one table read per cycle on the single read port
// key range: the divide state subtracts the group width from the letter index until the rest is below it
// throughput: next transaction accepted in the out_valid cycle; the receiver cannot stall
// synchronous active-low reset clears count, rotation index, mode and strobe; table keeps contents
module instance_selector_policy #(
  parameter int MAX_INSTANCES = isp_pkg::MAX_INST_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  isp_pkg::in_item_t    in_item,
  output logic                 out_valid,
  output isp_pkg::out_result_t out_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_data
);
  import isp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  isp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  isp_dp #(
    .MAX_INSTANCES (MAX_INSTANCES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

@@ design/isp_checker.sv @@
module isp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input isp_pkg::out_result_t out_result
);
  import isp_pkg::*;

  // one result per transaction, never two in a row
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result not aligned with end of busy");

  a_reject_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result.status != ST_OK)) |-> (out_result.chosen_slot == 4'd0))
    else $error("rejected transaction reports a slot");

endmodule

bind instance_selector_policy isp_checker u_isp_checker (.*);
